>>> rtl/core/szdd_pkg.sv
// ----------------------------------------------------------------------------
// szdd_pkg
// Types, constants and header tables shared by the SZDD/LZSS decompressor.
// ----------------------------------------------------------------------------
package szdd_pkg;

    // history window geometry
    localparam int WINDOW_SIZE = 4096;
    localparam int LOOKAHEAD   = 16;
    localparam int WIN_AW      = $clog2(WINDOW_SIZE);
    localparam int FILL_W      = WIN_AW + 1;

    localparam logic [WIN_AW-1:0] WP_RESET   = WIN_AW'(WINDOW_SIZE - LOOKAHEAD);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WINDOW_SIZE);
    localparam logic [7:0]        SPACE_BYTE = 8'h20;

    // header layout
    localparam logic [3:0] HDR_LEN      = 4'd14;
    localparam logic [3:0] HDR_KIND_POS = 4'd3;
    localparam logic [3:0] HDR_LAST_POS = 4'd13;
    localparam logic [3:0] SZDD_MAGIC_LEN = 4'd8;
    localparam logic [3:0] KWAJ_MAGIC_LEN = 4'd12;

    // match token fields
    localparam logic [4:0] MATCH_MIN = 5'd3;

    // result status codes
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_FORMAT  = 2'd1;
    localparam logic [1:0] ST_VERSION = 2'd2;

    typedef enum logic [1:0] {
        KIND_UNDECIDED = 2'd0,
        KIND_SZDD      = 2'd1,
        KIND_KWAJ      = 2'd2,
        KIND_NONE      = 2'd3
    } hdr_kind_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_of_run;
    } result_t;

    // expected SZDD header bytes 0..7
    function automatic logic [7:0] szdd_magic(input logic [2:0] n);
        logic [7:0] v;
        unique case (n)
            3'd0: v = 8'h53;
            3'd1: v = 8'h5A;
            3'd2: v = 8'h44;
            3'd3: v = 8'h44;
            3'd4: v = 8'h88;
            3'd5: v = 8'hF0;
            3'd6: v = 8'h27;
            3'd7: v = 8'h33;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // expected KWAJ header bytes 0..11
    function automatic logic [7:0] kwaj_magic(input logic [3:0] n);
        logic [7:0] v;
        unique case (n)
            4'd0:  v = 8'h4B;
            4'd1:  v = 8'h57;
            4'd2:  v = 8'h41;
            4'd3:  v = 8'h4A;
            4'd4:  v = 8'h88;
            4'd5:  v = 8'hF0;
            4'd6:  v = 8'h27;
            4'd7:  v = 8'hD1;
            4'd8:  v = 8'h03;
            4'd9:  v = 8'h00;
            4'd10: v = 8'h12;
            4'd11: v = 8'h00;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/szdd_if.sv
// ----------------------------------------------------------------------------
// szdd channel interfaces
// Valid/ready channels for compressed input bytes and decoded results.
// ----------------------------------------------------------------------------
interface szdd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface szdd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_of_run,
                    output ready);
endinterface

>>> rtl/core/szdd_lzss_decompressor.sv
// ----------------------------------------------------------------------------
// szdd_lzss_decompressor
// Checks the 14-byte SZDD header, then expands LZSS groups through a
// 4096-byte history window held in a single synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | role
//  comp    | in  | in_byte[7:0]                     | compressed file, one byte a beat
//  data    | out | out_byte[7:0] status[1:0] last   | decoded byte or error code
//
//  A match of length L issues one window read a cycle while the output queue
//  has credit, bounded by the single read port of the window RAM; no new
//  compressed byte is accepted until the copy ends.
//  Reset leaves the RAM untouched: a fill count of bytes written since reset
//  makes unwritten entries read as spaces, so no clearing pass is needed.
//  A two-beat output queue with credit-based issue keeps the copy running
//  at full rate and simply pauses it while the data side stalls.
// ----------------------------------------------------------------------------
module szdd_lzss_decompressor (
    input  logic              clk,
    input  logic              rst_n,
    szdd_in_if.sink           comp,
    szdd_out_if.source        data
);
    import szdd_pkg::*;

    // window RAM
    logic [7:0] window_mem [0:WINDOW_SIZE-1];
    logic [7:0] mem_q_reg;

    // header state
    logic [3:0]  hdr_count_reg, hdr_count_next;
    hdr_kind_t   hdr_kind_reg, hdr_kind_next;
    logic        hdr_mm_reg, hdr_mm_next;
    logic        hdr_mm_calc;
    logic        halted_reg, halted_next;

    // group decode state
    logic [7:0]  flag_bits_reg, flag_bits_next;
    logic [3:0]  flag_pos_reg, flag_pos_next;
    logic        phase_reg, phase_next;
    logic [7:0]  offset_low_reg, offset_low_next;

    // copy engine
    logic              copy_active_reg, copy_active_next;
    logic [WIN_AW-1:0] copy_src_reg, copy_src_next;
    logic [4:0]        copy_rem_reg, copy_rem_next;
    logic              copy_issue;

    // read/resolve stage
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_from_mem_reg, s1_from_mem_next;
    result_t     s1_res_reg, s1_res_next;
    logic        fwd_hit_reg;
    logic [7:0]  fwd_data_reg;
    logic        rd_written_reg;
    result_t     s2_res;

    // window write side
    logic [WIN_AW-1:0] wp_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              win_we;
    logic [WIN_AW-1:0] src_rel;

    // output queue
    result_t     fifo_mem_reg [0:1];
    logic        fifo_rd_ptr_reg;
    logic        fifo_wr_ptr_reg;
    logic [1:0]  fifo_count_reg;
    logic        pop;
    logic [2:0]  credit_use;
    logic        issue_ok;

    logic        accept;
    logic        direct_issue;
    result_t     direct_res;
    logic [7:0]  b;

    assign b      = comp.in_byte;
    assign pop    = data.valid && data.ready;
    assign credit_use = 3'(fifo_count_reg) - 3'(pop) + 3'(s1_valid_reg);
    assign issue_ok   = credit_use < 3'd2;

    assign comp.ready = !copy_active_reg && issue_ok;
    assign accept     = comp.valid && comp.ready;
    assign copy_issue = copy_active_reg && issue_ok;

    // header mismatch including the current byte
    always_comb
    begin
        hdr_mm_calc = hdr_mm_reg;
        if (hdr_kind_reg == KIND_SZDD && hdr_count_reg < SZDD_MAGIC_LEN)
        begin
            if (b != szdd_magic(hdr_count_reg[2:0]))
                hdr_mm_calc = 1'b1;
        end
        else if (hdr_kind_reg == KIND_KWAJ && hdr_count_reg < KWAJ_MAGIC_LEN)
        begin
            if (b != kwaj_magic(hdr_count_reg))
                hdr_mm_calc = 1'b1;
        end
    end

    // byte decode and copy sequencing
    always_comb
    begin
        hdr_count_next   = hdr_count_reg;
        hdr_kind_next    = hdr_kind_reg;
        hdr_mm_next      = hdr_mm_reg;
        halted_next      = halted_reg;
        flag_bits_next   = flag_bits_reg;
        flag_pos_next    = flag_pos_reg;
        phase_next       = phase_reg;
        offset_low_next  = offset_low_reg;
        copy_active_next = copy_active_reg;
        copy_src_next    = copy_src_reg;
        copy_rem_next    = copy_rem_reg;
        direct_issue     = 1'b0;
        direct_res       = '{out_byte: 8'h00, status: ST_DATA, last_of_run: 1'b1};

        if (accept && !halted_reg)
        begin
            priority if (hdr_count_reg < HDR_LEN)
            begin
                hdr_count_next = hdr_count_reg + 4'd1;
                if (hdr_count_reg == 4'd0)
                begin
                    if (b == szdd_magic(3'd0))
                        hdr_kind_next = KIND_SZDD;
                    else if (b == kwaj_magic(4'd0))
                        hdr_kind_next = KIND_KWAJ;
                    else
                        hdr_kind_next = KIND_NONE;
                    hdr_mm_next = 1'b0;
                end
                else
                begin
                    hdr_mm_next = hdr_mm_calc;
                    if (hdr_count_reg == HDR_KIND_POS &&
                        (hdr_kind_reg == KIND_NONE || hdr_mm_calc))
                    begin
                        direct_issue      = 1'b1;
                        direct_res.status = ST_FORMAT;
                        halted_next       = 1'b1;
                    end
                    else if (hdr_count_reg == HDR_LAST_POS &&
                             !(hdr_kind_reg == KIND_SZDD && !hdr_mm_calc))
                    begin
                        direct_issue      = 1'b1;
                        direct_res.status = (hdr_kind_reg == KIND_KWAJ && !hdr_mm_calc)
                                            ? ST_VERSION : ST_FORMAT;
                        halted_next       = 1'b1;
                    end
                end
            end
            else if (flag_pos_reg[3])
            begin
                flag_bits_next = b;
                flag_pos_next  = 4'd0;
                phase_next     = 1'b0;
            end
            else if (flag_bits_reg[flag_pos_reg[2:0]])
            begin
                direct_issue        = 1'b1;
                direct_res.out_byte = b;
                flag_pos_next       = flag_pos_reg + 4'd1;
            end
            else if (!phase_reg)
            begin
                offset_low_next = b;
                phase_next      = 1'b1;
            end
            else
            begin
                copy_active_next = 1'b1;
                copy_src_next    = {b[7:4], offset_low_reg};
                copy_rem_next    = {1'b0, b[3:0]} + MATCH_MIN;
                phase_next       = 1'b0;
                flag_pos_next    = flag_pos_reg + 4'd1;
            end
        end

        if (copy_issue)
        begin
            copy_src_next = copy_src_reg + WIN_AW'(1);
            copy_rem_next = copy_rem_reg - 5'd1;
            if (copy_rem_reg == 5'd1)
                copy_active_next = 1'b0;
        end
    end

    // read stage entry
    always_comb
    begin
        s1_valid_next    = copy_issue || direct_issue;
        s1_from_mem_next = copy_issue;
        s1_res_next      = direct_res;
        if (copy_issue)
        begin
            s1_res_next.out_byte    = 8'h00;
            s1_res_next.status      = ST_DATA;
            s1_res_next.last_of_run = (copy_rem_reg == 5'd1);
        end
    end

    // resolve stage: pick forwarded, stored or reset-value byte
    always_comb
    begin
        s2_res = s1_res_reg;
        if (s1_from_mem_reg)
        begin
            if (fwd_hit_reg)
                s2_res.out_byte = fwd_data_reg;
            else if (rd_written_reg)
                s2_res.out_byte = mem_q_reg;
            else
                s2_res.out_byte = SPACE_BYTE;
        end
    end

    assign win_we  = s1_valid_reg && (s1_res_reg.status == ST_DATA);
    assign src_rel = copy_src_reg - WP_RESET;

    // window RAM, one write and one read port
    always_ff @(posedge clk)
    begin
        if (copy_issue)
            mem_q_reg <= window_mem[copy_src_reg];
        if (win_we)
            window_mem[wp_reg] <= s2_res.out_byte;
    end

    // read side bookkeeping, forward when the read hits the entry being written
    always_ff @(posedge clk)
    begin
        if (copy_issue)
        begin
            fwd_hit_reg    <= win_we && (wp_reg == copy_src_reg);
            fwd_data_reg   <= s2_res.out_byte;
            rd_written_reg <= {1'b0, src_rel} < fill_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg   <= 4'd0;
            hdr_kind_reg    <= KIND_UNDECIDED;
            hdr_mm_reg      <= 1'b0;
            halted_reg      <= 1'b0;
            flag_bits_reg   <= 8'h00;
            flag_pos_reg    <= 4'd8;
            phase_reg       <= 1'b0;
            offset_low_reg  <= 8'h00;
            copy_active_reg <= 1'b0;
            copy_src_reg    <= '0;
            copy_rem_reg    <= 5'd0;
            s1_valid_reg    <= 1'b0;
            s1_from_mem_reg <= 1'b0;
            wp_reg          <= WP_RESET;
            fill_reg        <= '0;
        end
        else
        begin
            hdr_count_reg   <= hdr_count_next;
            hdr_kind_reg    <= hdr_kind_next;
            hdr_mm_reg      <= hdr_mm_next;
            halted_reg      <= halted_next;
            flag_bits_reg   <= flag_bits_next;
            flag_pos_reg    <= flag_pos_next;
            phase_reg       <= phase_next;
            offset_low_reg  <= offset_low_next;
            copy_active_reg <= copy_active_next;
            copy_src_reg    <= copy_src_next;
            copy_rem_reg    <= copy_rem_next;
            s1_valid_reg    <= s1_valid_next;
            s1_from_mem_reg <= s1_from_mem_next;
            if (win_we)
            begin
                wp_reg <= wp_reg + WIN_AW'(1);
                if (fill_reg != FILL_FULL)
                    fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
            s1_res_reg <= s1_res_next;
    end

    // output queue, two beats deep
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            fifo_mem_reg[fifo_wr_ptr_reg] <= s2_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_rd_ptr_reg <= 1'b0;
            fifo_wr_ptr_reg <= 1'b0;
            fifo_count_reg  <= 2'd0;
        end
        else
        begin
            if (s1_valid_reg)
                fifo_wr_ptr_reg <= !fifo_wr_ptr_reg;
            if (pop)
                fifo_rd_ptr_reg <= !fifo_rd_ptr_reg;
            fifo_count_reg <= fifo_count_reg + 2'(s1_valid_reg) - 2'(pop);
        end
    end

    assign data.valid       = fifo_count_reg != 2'd0;
    assign data.out_byte    = fifo_mem_reg[fifo_rd_ptr_reg].out_byte;
    assign data.status      = fifo_mem_reg[fifo_rd_ptr_reg].status;
    assign data.last_of_run = fifo_mem_reg[fifo_rd_ptr_reg].last_of_run;

endmodule

>>> bench/szdd_lzss_decompressor_tb.sv
// ----------------------------------------------------------------------------
// szdd_lzss_decompressor_tb
// Feeds one SZDD stream (a good header, then LZSS groups of literals and
// window copies) through the compressed-byte channel under several idling
// patterns. Every decoded beat is compared with a software expander that
// keeps its own 4096-byte history window.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module szdd_lzss_decompressor_tb;
    import szdd_pkg::*;

    // expected-output tracker: decodes accepted bytes and checks decoded beats
    class szdd_stream_checker;
        logic [7:0]        window [WINDOW_SIZE];
        logic [WIN_AW-1:0] wr_pos;
        logic [7:0]        szdd_sig [8];
        logic [7:0]        kwaj_sig [12];
        int                hdr_count;
        hdr_kind_t         kind;
        bit                hdr_bad;
        bit                stopped;
        logic [7:0]        flags;
        int                flag_idx;
        bit                want_second;
        logic [7:0]        off_lo;
        result_t           pending_bytes [$];
        int                checked;
        int                mismatches;

        function new();
            foreach (window[i]) window[i] = SPACE_BYTE;
            szdd_sig    = '{8'h53, 8'h5A, 8'h44, 8'h44, 8'h88, 8'hF0, 8'h27, 8'h33};
            kwaj_sig    = '{8'h4B, 8'h57, 8'h41, 8'h4A, 8'h88, 8'hF0, 8'h27, 8'hD1,
                            8'h03, 8'h00, 8'h12, 8'h00};
            wr_pos      = WP_RESET;
            hdr_count   = 0;
            kind        = KIND_UNDECIDED;
            hdr_bad     = 1'b0;
            stopped     = 1'b0;
            flags       = 8'h00;
            flag_idx    = 8;
            want_second = 1'b0;
            off_lo      = 8'h00;
            checked     = 0;
            mismatches  = 0;
        endfunction

        task report(input string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function void push_error(input logic [1:0] code);
            stopped = 1'b1;
            pending_bytes.push_back('{out_byte: 8'h00, status: code, last_of_run: 1'b1});
        endfunction

        function void put_byte(input logic [7:0] v);
            window[wr_pos] = v;
            wr_pos++;
            pending_bytes.push_back('{out_byte: v, status: ST_DATA, last_of_run: 1'b0});
        endfunction

        // one accepted compressed byte
        function void take_comp_byte(input logic [7:0] b);
            int                n;
            int                run_len;
            logic [WIN_AW-1:0] src;
            if (stopped)
                return;

            // header bytes
            if (hdr_count < HDR_LEN)
            begin
                n = hdr_count;
                hdr_count++;
                if (n == 0)
                begin
                    kind    = (b == szdd_sig[0]) ? KIND_SZDD :
                              (b == kwaj_sig[0]) ? KIND_KWAJ : KIND_NONE;
                    hdr_bad = 1'b0;
                    return;
                end
                if (kind == KIND_SZDD && n < 8)
                begin
                    if (b != szdd_sig[n]) hdr_bad = 1'b1;
                end
                else if (kind == KIND_KWAJ && n < 12)
                begin
                    if (b != kwaj_sig[n]) hdr_bad = 1'b1;
                end
                if (n == 3 && (kind == KIND_NONE || hdr_bad))
                    push_error(ST_FORMAT);
                else if (n == HDR_LEN - 1 && !(kind == KIND_SZDD && !hdr_bad))
                    push_error((kind == KIND_KWAJ && !hdr_bad) ? ST_VERSION : ST_FORMAT);
                return;
            end

            // flag byte opens a group
            if (flag_idx >= 8)
            begin
                flags       = b;
                flag_idx    = 0;
                want_second = 1'b0;
                return;
            end

            if (flags[flag_idx])
            begin
                put_byte(b);
                flag_idx++;
            end
            else if (!want_second)
            begin
                off_lo      = b;
                want_second = 1'b1;
                return;
            end
            else
            begin
                // window copy, one byte at a time so overlaps repeat data
                src     = {b[7:4], off_lo};
                run_len = int'(b[3:0]) + 3;
                for (int t = 0; t < run_len; t++)
                begin
                    put_byte(window[src]);
                    src++;
                end
                want_second = 1'b0;
                flag_idx++;
            end
            pending_bytes[pending_bytes.size() - 1].last_of_run = 1'b1;
        endfunction

        // one accepted decoded beat against the oldest expectation
        task match_result(input result_t seen);
            result_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("beat with nothing expected: byte %02h status %0d last %0b",
                                 seen.out_byte, seen.status, seen.last_of_run));
                return;
            end
            want = pending_bytes.pop_front();
            checked++;
            if (seen.out_byte !== want.out_byte)
                report($sformatf("beat %0d out_byte %02h, expected %02h",
                                 checked, seen.out_byte, want.out_byte));
            if (seen.status !== want.status)
                report($sformatf("beat %0d status %0d, expected %0d",
                                 checked, seen.status, want.status));
            if (seen.last_of_run !== want.last_of_run)
                report($sformatf("beat %0d last_of_run %0b, expected %0b",
                                 checked, seen.last_of_run, want.last_of_run));
        endtask
    endclass

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 450;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 64;
    localparam int TIMEOUT_CYCLES = 400000;

    logic clk;
    logic rst_n;

    szdd_in_if  comp_ch ();
    szdd_out_if data_ch ();

    szdd_lzss_decompressor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .comp  (comp_ch),
        .data  (data_ch)
    );

    szdd_stream_checker expander = new();

    logic [7:0]        stim_q [$];
    logic [WIN_AW-1:0] gen_pos = WP_RESET;
    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    int                hold_ticket    = 0;
    int                n_sent         = 0;
    int                n_literal      = 0;
    int                n_match        = 0;
    int                n_overlap      = 0;

    // clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // beat monitor: inputs are noted before outputs at the same edge
    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n === 1'b1)
        begin
            if (comp_ch.valid && comp_ch.ready)
                expander.take_comp_byte(comp_ch.in_byte);
            if (data_ch.valid && data_ch.ready)
            begin
                seen = '{out_byte: data_ch.out_byte, status: data_ch.status,
                         last_of_run: data_ch.last_of_run};
                expander.match_result(seen);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_served;
        hold_served = 0;
        data_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != hold_served)
            begin
                hold_served = hold_ticket;
                data_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            data_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void add_literal(input logic [7:0] v);
        stim_q.push_back(v);
        gen_pos++;
        n_literal++;
    endfunction

    function automatic void add_match(input logic [WIN_AW-1:0] off, input int len);
        logic [WIN_AW-1:0] gap;
        stim_q.push_back(off[7:0]);
        stim_q.push_back({off[11:8], 4'(len - 3)});
        gap = gen_pos - off;
        if (gap != 0 && gap < len)
            n_overlap++;
        gen_pos += WIN_AW'(len);
        n_match++;
    endfunction

    // one full group: random flag, then its eight tokens
    function automatic void add_group();
        logic [7:0]        flag;
        logic [WIN_AW-1:0] off;
        int                len;
        flag = 8'($urandom);
        stim_q.push_back(flag);
        for (int k = 0; k < 8; k++)
        begin
            if (flag[k])
                add_literal(8'($urandom));
            else
            begin
                case ($urandom_range(9))
                    0:       off = WIN_AW'($urandom);
                    1:       off = gen_pos - 1'b1;
                    default: off = gen_pos - WIN_AW'($urandom_range(40, 1));
                endcase
                case ($urandom_range(5))
                    0:       len = 3;
                    1:       len = 18;
                    default: len = $urandom_range(18, 3);
                endcase
                add_match(off, len);
            end
        end
    endfunction

    // offer one byte, idling at random first, and wait for its beat
    task automatic send_byte(input logic [7:0] v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            comp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        comp_ch.valid   <= 1'b1;
        comp_ch.in_byte <= v;
        do
            @(posedge clk);
        while (comp_ch.ready !== 1'b1);
        n_sent++;
    endtask

    task automatic send_queued();
        while (stim_q.size() != 0)
            send_byte(stim_q.pop_front());
    endtask

    // stop offering until every expected beat has come back
    task automatic drain();
        comp_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expander.pending_bytes.size() != 0);
    endtask

    // stimulus
    initial
    begin
        int src_pct  [4];
        int sink_pct [4];
        int phase_end;
        src_pct  = '{0, 87, 0, 15};
        sink_pct = '{0, 0, 87, 15};
        rst_n           <= 1'b0;
        comp_ch.valid   <= 1'b0;
        comp_ch.in_byte <= 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // good SZDD header, ignored bytes at the extremes
        stim_q = '{8'h53, 8'h5A, 8'h44, 8'h44, 8'h88, 8'hF0, 8'h27, 8'h33,
                   8'h00, 8'hFF, 8'h00, 8'hFF, 8'hA5, 8'h5A};
        // directed group: extreme literals, copy from unwritten window start,
        // copy from the top offset wrapping round, longest overlapping copy
        stim_q.push_back(8'hE3);
        add_literal(8'h00);
        add_literal(8'hFF);
        add_match(12'h000, 3);
        add_match(12'hFFF, 18);
        add_match(gen_pos - 1'b1, 18);
        add_literal(8'h80);
        add_literal(8'h7F);
        add_literal(8'h55);
        send_queued();
        drain();

        // random groups under each idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   = src_pct[ph];
            sink_stall_pct <= sink_pct[ph];
            phase_end      = n_sent + RANDOM_ITEMS / 4;
            if (ph == 0)
                hold_ticket <= hold_ticket + 1;
            while (n_sent < phase_end)
            begin
                add_group();
                send_queued();
            end
            drain();
        end

        // truncated tail: flag byte and the first half of a match
        stim_q.push_back(8'h00);
        stim_q.push_back(8'($urandom));
        send_queued();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expander.pending_bytes.size() != 0)
            expander.report($sformatf("%0d expected beats never arrived",
                                      expander.pending_bytes.size()));
        $display("Covered %0d compressed bytes: %0d literals, %0d copies (%0d overlapping).",
                 n_sent, n_literal, n_match, n_overlap);
        $display("Checked %0d decoded beats across four idling patterns and one long hold-off.",
                 expander.checked);
        if (expander.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[%0t] watchdog expired with %0d beats outstanding",
                 $realtime, expander.pending_bytes.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/szdd_pkg.sv
rtl/core/szdd_if.sv
rtl/core/szdd_lzss_decompressor.sv
bench/szdd_lzss_decompressor_tb.sv
